// ----- rtl/core/b40cc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base-40 callsign codec package
// Shared widths, command and state types, and the character tables used by
// the front, the command queue and the back end of the codec.
// ----------------------------------------------------------------------------
package b40cc_pkg;

    localparam int WORD_W  = 48;
    localparam int CHAR_W  = 8;
    localparam int DIGIT_W = 6;

    // Saturating character counter of the encoder.
    localparam int                 COUNT_W   = 4;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;

    // Special texts.
    localparam int TXT_ALL_LEN = 3;
    localparam int TXT_INV_LEN = 7;
    localparam int TXT_IDX_W   = 3;

    // Divide-by-40 unit: one byte of the dividend per cycle.
    localparam int                 DIV_CHUNK_W = 8;
    localparam int                 DIV_STEPS   = WORD_W / DIV_CHUNK_W;
    localparam int                 DIV_STEP_W  = $clog2(DIV_STEPS);
    localparam int                 DIV_V_W     = DIGIT_W + DIV_CHUNK_W;
    localparam int                 RECIP_W     = 11;
    localparam logic [RECIP_W-1:0] RECIP_40    = 11'd1638;
    localparam int                 RECIP_SHIFT = 16;
    localparam logic [DIGIT_W-1:0] RADIX       = 6'd40;

    localparam int QUEUE_DEPTH = 2;

    // Input mode and result kind codes.
    localparam logic MODE_ENC  = 1'b0;
    localparam logic MODE_DEC  = 1'b1;
    localparam logic KIND_WORD = 1'b0;
    localparam logic KIND_CHAR = 1'b1;

    typedef enum logic [1:0] {
        CMD_ENC_CHAR,
        CMD_DEC_ALL,
        CMD_DEC_INVALID,
        CMD_DEC_NUM
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [CHAR_W-1:0]   chr;
        logic [DIGIT_W-1:0]  digit;
        logic                bad;
        logic                last;
        logic [WORD_W-1:0]   word;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_EMIT,
        BK_TEXT
    } back_state_t;

    typedef enum logic {
        TXT_ALL,
        TXT_INVALID
    } txt_sel_t;

    // Character to digit: bit DIGIT_W is set when the character has a mapping.
    function automatic logic [DIGIT_W:0] digit_of(input logic [CHAR_W-1:0] c);
        logic [DIGIT_W:0] r;
        r = '0;
        if (c >= "A" && c <= "Z") begin
            r = {1'b1, DIGIT_W'(c - "A" + 8'd1)};
        end
        else if (c >= "0" && c <= "9") begin
            r = {1'b1, DIGIT_W'(c - "0" + 8'd27)};
        end
        else if (c == "-") begin
            r = {1'b1, 6'd37};
        end
        else if (c == "/") begin
            r = {1'b1, 6'd38};
        end
        else if (c == ".") begin
            r = {1'b1, 6'd39};
        end
        return r;
    endfunction

    // Digit to character.
    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] r;
        r = " ";
        if (d == 6'd0) begin
            r = " ";
        end
        else if (d <= 6'd26) begin
            r = "A" - 8'd1 + CHAR_W'(d);
        end
        else if (d <= 6'd36) begin
            r = "0" + CHAR_W'(d - 6'd27);
        end
        else if (d == 6'd37) begin
            r = "-";
        end
        else if (d == 6'd38) begin
            r = "/";
        end
        else if (d == 6'd39) begin
            r = ".";
        end
        return r;
    endfunction

    function automatic logic [CHAR_W-1:0] txt_all_char(input logic [TXT_IDX_W-1:0] i);
        logic [CHAR_W-1:0] r;
        case (i)
            3'd0:    r = "A";
            3'd1:    r = "L";
            3'd2:    r = "L";
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [CHAR_W-1:0] txt_inv_char(input logic [TXT_IDX_W-1:0] i);
        logic [CHAR_W-1:0] r;
        case (i)
            3'd0:    r = "I";
            3'd1:    r = "N";
            3'd2:    r = "V";
            3'd3:    r = "A";
            3'd4:    r = "L";
            3'd5:    r = "I";
            3'd6:    r = "D";
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/core/base40_callsign_codec.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base-40 callsign codec
// Encodes ASCII callsigns into 48-bit base-40 addresses and decodes
// addresses back into characters.
// ----------------------------------------------------------------------------
// Usage: requests enter through a queue-style port (push, full) with mode,
// char_in, char_last and word_in. Results leave through a queue-style port
// (empty, pop) as kind, word_out, char_out and run_last.
// An encode request carries one character; the character marked char_last
// yields one encoded word. A decode request yields up to MAX_CHARS
// characters, the final one marked by run_last.
// Path: a request passes the front register and the command queue before
// the back end takes it, and each result is written to the result register.
// Decode of a plain word: after the back end takes the command, each digit
// comes from one pass of the divide-by-40 unit, which consumes one byte of
// the word per cycle, followed by an emit state. The texts ALL and INVALID
// come out at one character per cycle while the result register is popped.
// A two-entry command queue sits between front and back; when the result
// register is not popped, the back end stalls and the queue, then the front,
// fill until full rises. Reset empties all stages and clears strict_reg.
// ----------------------------------------------------------------------------
module base40_callsign_codec #(
    parameter int MAX_CHARS = 9
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic                         mode,
    input  logic [b40cc_pkg::CHAR_W-1:0] char_in,
    input  logic                         char_last,
    input  logic [b40cc_pkg::WORD_W-1:0] word_in,
    output logic                         empty,
    input  logic                         pop,
    output logic                         kind,
    output logic [b40cc_pkg::WORD_W-1:0] word_out,
    output logic [b40cc_pkg::CHAR_W-1:0] char_out,
    output logic                         run_last,
    input  logic                         cfg_wen,
    input  logic                         cfg_wdata
);
    import b40cc_pkg::*;

    logic front_valid;
    cmd_t front_cmd;
    logic q_full;
    logic q_valid;
    cmd_t q_cmd;
    logic q_pop;

    // Request classification.
    b40cc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .mode      (mode),
        .char_in   (char_in),
        .char_last (char_last),
        .word_in   (word_in),
        .cmd_valid (front_valid),
        .cmd       (front_cmd),
        .q_full    (q_full)
    );

    // Command buffering.
    b40cc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_cmd    (front_cmd),
        .full      (q_full),
        .out_valid (q_valid),
        .out_cmd   (q_cmd),
        .pop       (q_pop)
    );

    // Encoding, division and result output.
    b40cc_back #(
        .MAX_CHARS (MAX_CHARS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .cmd_valid (q_valid),
        .cmd       (q_cmd),
        .cmd_pop   (q_pop),
        .empty     (empty),
        .pop       (pop),
        .kind      (kind),
        .word_out  (word_out),
        .char_out  (char_out),
        .run_last  (run_last)
    );

endmodule

// ----- rtl/core/b40cc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Codec front end
// Accepts input requests, maps characters to digits, sorts decode words into
// the special texts and plain numbers, and hands commands to the queue.
// ----------------------------------------------------------------------------
module b40cc_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic                         mode,
    input  logic [b40cc_pkg::CHAR_W-1:0] char_in,
    input  logic                         char_last,
    input  logic [b40cc_pkg::WORD_W-1:0] word_in,
    output logic                         cmd_valid,
    output b40cc_pkg::cmd_t              cmd,
    input  logic                         q_full
);
    import b40cc_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    cmd_t             cmd_reg;
    cmd_t             cmd_next;
    logic             accept;
    logic [DIGIT_W:0] dmap;

    // The stage holds one request until the queue has room for it.
    assign full      = valid_reg && q_full;
    assign accept    = push && !full;
    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

    // Classify the incoming request.
    always_comb
    begin
        dmap     = digit_of(char_in);
        cmd_next = cmd_reg;
        if (accept)
        begin
            cmd_next.chr   = char_in;
            cmd_next.digit = dmap[DIGIT_W-1:0];
            cmd_next.bad   = !dmap[DIGIT_W];
            cmd_next.last  = char_last;
            cmd_next.word  = word_in;
            if (mode == MODE_ENC)
            begin
                cmd_next.kind = CMD_ENC_CHAR;
            end
            else if (&word_in)
            begin
                cmd_next.kind = CMD_DEC_ALL;
            end
            else if (word_in == '0)
            begin
                cmd_next.kind = CMD_DEC_INVALID;
            end
            else
            begin
                cmd_next.kind = CMD_DEC_NUM;
            end
        end
    end

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (q_full)
        begin
            valid_next = valid_reg;
        end
        else
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule

// ----- rtl/core/b40cc_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command queue
// Short first-in first-out queue of classified commands between the front
// end and the back end, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module b40cc_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  b40cc_pkg::cmd_t in_cmd,
    output logic            full,
    output logic            out_valid,
    output b40cc_pkg::cmd_t out_cmd,
    input  logic            pop
);
    import b40cc_pkg::*;

    localparam int                 PTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int                 CNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0]   PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0]   CNT_FULL = CNT_W'(QUEUE_DEPTH);

    cmd_t             entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CNT_FULL);
    assign out_valid = (count_reg != '0);
    assign out_cmd   = entries_reg[rd_ptr_reg];
    assign do_push   = in_valid && !full;
    assign do_pop    = pop && out_valid;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// ----- rtl/core/b40cc_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Codec back end
// Runs the base-40 encoder accumulator, the byte-serial divide-by-40 unit and
// the special-text sequencer, and holds the result register.
// ----------------------------------------------------------------------------
module b40cc_back #(
    parameter int MAX_CHARS = 9
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wen,
    input  logic                         cfg_wdata,
    input  logic                         cmd_valid,
    input  b40cc_pkg::cmd_t              cmd,
    output logic                         cmd_pop,
    output logic                         empty,
    input  logic                         pop,
    output logic                         kind,
    output logic [b40cc_pkg::WORD_W-1:0] word_out,
    output logic [b40cc_pkg::CHAR_W-1:0] char_out,
    output logic                         run_last
);
    import b40cc_pkg::*;

    localparam int               N_W      = $clog2(MAX_CHARS + 1);
    localparam int               ALL_N    = (TXT_ALL_LEN < MAX_CHARS) ? TXT_ALL_LEN : MAX_CHARS;
    localparam int               INV_N    = (TXT_INV_LEN < MAX_CHARS) ? TXT_INV_LEN : MAX_CHARS;
    localparam logic [N_W-1:0]   N_LAST   = N_W'(MAX_CHARS - 1);
    localparam logic [N_W-1:0]   ALL_LAST = N_W'(ALL_N - 1);
    localparam logic [N_W-1:0]   INV_LAST = N_W'(INV_N - 1);
    localparam logic [DIV_STEP_W-1:0] STEP_LAST = DIV_STEP_W'(DIV_STEPS - 1);
    localparam int               PROD_W   = DIV_V_W + RECIP_W;

    back_state_t state_reg;
    back_state_t state_next;

    // Encoder state.
    logic [WORD_W-1:0]  acc_reg;
    logic [WORD_W-1:0]  acc_next;
    logic [WORD_W-1:0]  weight_reg;
    logic [WORD_W-1:0]  weight_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               m_all_reg;
    logic               m_all_next;
    logic               m_inv_reg;
    logic               m_inv_next;
    logic               bad_reg;
    logic               bad_next;
    logic               strict_reg;

    // Decoder state.
    logic [WORD_W-1:0]     w_reg;
    logic [WORD_W-1:0]     w_next;
    logic [DIGIT_W-1:0]    rem_reg;
    logic [DIGIT_W-1:0]    rem_next;
    logic [DIV_STEP_W-1:0] step_reg;
    logic [DIV_STEP_W-1:0] step_next;
    logic [N_W-1:0]        n_reg;
    logic [N_W-1:0]        n_next;
    txt_sel_t              sel_reg;
    txt_sel_t              sel_next;

    // Result register.
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              kind_reg;
    logic              kind_next;
    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;
    logic [CHAR_W-1:0] char_reg;
    logic [CHAR_W-1:0] char_next;
    logic              last_reg;
    logic              last_next;
    logic              out_free;

    // Encoder datapath.
    logic [WORD_W+DIGIT_W-1:0] enc_prod;
    logic [WORD_W-1:0]         acc_sum;
    logic [WORD_W-1:0]         weight_x40;
    logic [COUNT_W-1:0]        count_inc;
    logic                      all_hit;
    logic                      inv_hit;
    logic                      bad_new;
    logic [WORD_W-1:0]         enc_word;

    // Divide-by-40 datapath.
    logic [DIV_V_W-1:0]     div_v;
    logic [PROD_W-1:0]      div_prod;
    logic [DIV_CHUNK_W-1:0] div_q0;
    logic [DIV_V_W-1:0]     div_q0x40;
    logic [DIV_V_W-1:0]     div_r0;
    logic                   div_fix;
    logic [DIV_CHUNK_W-1:0] div_q;
    logic [DIGIT_W-1:0]     div_r;

    logic              emit_last;
    logic              text_last;
    logic [CHAR_W-1:0] text_char;

    assign empty    = !out_valid_reg;
    assign kind     = kind_reg;
    assign word_out = word_reg;
    assign char_out = char_reg;
    assign run_last = last_reg;
    assign out_free = !out_valid_reg || pop;

    // Encoder step: add digit times weight, advance weight, track special texts.
    always_comb
    begin
        enc_prod   = cmd.digit * weight_reg;
        acc_sum    = acc_reg + enc_prod[WORD_W-1:0];
        weight_x40 = (weight_reg << 5) + (weight_reg << 3);
        count_inc  = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;
        all_hit    = m_all_reg && (count_reg < COUNT_W'(TXT_ALL_LEN))
                     && (txt_all_char(TXT_IDX_W'(count_reg)) == cmd.chr);
        inv_hit    = m_inv_reg && (count_reg < COUNT_W'(TXT_INV_LEN))
                     && (txt_inv_char(TXT_IDX_W'(count_reg)) == cmd.chr);
        bad_new    = bad_reg || cmd.bad;
        if (all_hit && count_inc == COUNT_W'(TXT_ALL_LEN))
        begin
            enc_word = '1;
        end
        else if (inv_hit && count_inc == COUNT_W'(TXT_INV_LEN))
        begin
            enc_word = '0;
        end
        else if (strict_reg && bad_new)
        begin
            enc_word = '0;
        end
        else
        begin
            enc_word = acc_sum;
        end
    end

    // One byte of long division by 40 through a reciprocal and one correction.
    always_comb
    begin
        div_v     = {rem_reg, w_reg[WORD_W-1 -: DIV_CHUNK_W]};
        div_prod  = PROD_W'(div_v) * PROD_W'(RECIP_40);
        div_q0    = div_prod[RECIP_SHIFT +: DIV_CHUNK_W];
        div_q0x40 = (DIV_V_W'(div_q0) << 5) + (DIV_V_W'(div_q0) << 3);
        div_r0    = div_v - div_q0x40;
        div_fix   = (div_r0 >= DIV_V_W'(RADIX));
        div_q     = div_fix ? div_q0 + 1'b1 : div_q0;
        div_r     = div_fix ? DIGIT_W'(div_r0 - DIV_V_W'(RADIX)) : DIGIT_W'(div_r0);
    end

    // End-of-run detection for digits and special texts.
    always_comb
    begin
        emit_last = (w_reg == '0) || (n_reg == N_LAST);
        if (sel_reg == TXT_ALL)
        begin
            text_last = (n_reg == ALL_LAST);
            text_char = txt_all_char(TXT_IDX_W'(n_reg));
        end
        else
        begin
            text_last = (n_reg == INV_LAST);
            text_char = txt_inv_char(TXT_IDX_W'(n_reg));
        end
    end

    // Commands are taken only in idle; a final character waits for result room.
    assign cmd_pop = (state_reg == BK_IDLE) && cmd_valid
                     && ((cmd.kind != CMD_ENC_CHAR) || !cmd.last || out_free);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (cmd_pop)
                begin
                    case (cmd.kind)
                        CMD_ENC_CHAR:    state_next = BK_IDLE;
                        CMD_DEC_ALL:     state_next = BK_TEXT;
                        CMD_DEC_INVALID: state_next = BK_TEXT;
                        CMD_DEC_NUM:     state_next = BK_DIV;
                        default:         state_next = BK_IDLE;
                    endcase
                end
            end
            BK_DIV:
            begin
                if (step_reg == STEP_LAST)
                begin
                    state_next = BK_EMIT;
                end
            end
            BK_EMIT:
            begin
                if (out_free)
                begin
                    state_next = emit_last ? BK_IDLE : BK_DIV;
                end
            end
            BK_TEXT:
            begin
                if (out_free && text_last)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Datapath and result register updates.
    always_comb
    begin
        acc_next       = acc_reg;
        weight_next    = weight_reg;
        count_next     = count_reg;
        m_all_next     = m_all_reg;
        m_inv_next     = m_inv_reg;
        bad_next       = bad_reg;
        w_next         = w_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        n_next         = n_reg;
        sel_next       = sel_reg;
        out_valid_next = out_valid_reg && !pop;
        kind_next      = kind_reg;
        word_next      = word_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (cmd_pop)
                begin
                    case (cmd.kind)
                        CMD_ENC_CHAR:
                        begin
                            if (cmd.last)
                            begin
                                out_valid_next = 1'b1;
                                kind_next      = KIND_WORD;
                                word_next      = enc_word;
                                char_next      = '0;
                                last_next      = 1'b1;
                                acc_next       = '0;
                                weight_next    = WORD_W'(1);
                                count_next     = '0;
                                m_all_next     = 1'b1;
                                m_inv_next     = 1'b1;
                                bad_next       = 1'b0;
                            end
                            else
                            begin
                                acc_next    = acc_sum;
                                weight_next = weight_x40;
                                count_next  = count_inc;
                                m_all_next  = all_hit;
                                m_inv_next  = inv_hit;
                                bad_next    = bad_new;
                            end
                        end
                        CMD_DEC_ALL:
                        begin
                            sel_next = TXT_ALL;
                            n_next   = '0;
                        end
                        CMD_DEC_INVALID:
                        begin
                            sel_next = TXT_INVALID;
                            n_next   = '0;
                        end
                        CMD_DEC_NUM:
                        begin
                            w_next    = cmd.word;
                            rem_next  = '0;
                            step_next = '0;
                            n_next    = '0;
                        end
                        default:
                        begin
                            n_next = '0;
                        end
                    endcase
                end
            end
            BK_DIV:
            begin
                w_next    = {w_reg[WORD_W-DIV_CHUNK_W-1:0], div_q};
                rem_next  = div_r;
                step_next = step_reg + 1'b1;
            end
            BK_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_CHAR;
                    word_next      = '0;
                    char_next      = digit_char(rem_reg);
                    last_next      = emit_last;
                    rem_next       = '0;
                    step_next      = '0;
                    n_next         = n_reg + 1'b1;
                end
            end
            BK_TEXT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_CHAR;
                    word_next      = '0;
                    char_next      = text_char;
                    last_next      = text_last;
                    n_next         = n_reg + 1'b1;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && !pop;
            end
        endcase
    end

    // Control and encoder state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
            weight_reg    <= WORD_W'(1);
            count_reg     <= '0;
            m_all_reg     <= 1'b1;
            m_inv_reg     <= 1'b1;
            bad_reg       <= 1'b0;
            strict_reg    <= 1'b0;
            step_reg      <= '0;
            n_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            acc_reg       <= acc_next;
            weight_reg    <= weight_next;
            count_reg     <= count_next;
            m_all_reg     <= m_all_next;
            m_inv_reg     <= m_inv_next;
            bad_reg       <= bad_next;
            step_reg      <= step_next;
            n_reg         <= n_next;
            if (cfg_wen)
            begin
                strict_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        w_reg    <= w_next;
        rem_reg  <= rem_next;
        sel_reg  <= sel_next;
        kind_reg <= kind_next;
        word_reg <= word_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

endmodule

// ----- rtl/core/b40cc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Codec port checker
// Watches the top-level ports for result formats and stall behavior.
// ----------------------------------------------------------------------------
module b40cc_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         empty,
    input logic                         pop,
    input logic                         kind,
    input logic [b40cc_pkg::WORD_W-1:0] word_out,
    input logic [b40cc_pkg::CHAR_W-1:0] char_out,
    input logic                         run_last
);
    import b40cc_pkg::*;

    // An encoded word is always the only result of its request.
    a_word_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == KIND_WORD) |-> run_last)
        else $error("encoded word without run_last");

    // The unused payload field of a result is zero.
    a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((kind == KIND_WORD) ? (char_out == '0) : (word_out == '0)))
        else $error("unused result field not zero");

    // A decoded character is always one of the base-40 alphabet.
    a_char_alphabet: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == KIND_CHAR) |->
            ((char_out >= "A" && char_out <= "Z") || (char_out >= "0" && char_out <= "9")
             || char_out == "-" || char_out == "/" || char_out == "." || char_out == " "))
        else $error("decoded character outside the alphabet");

    // A stalled result holds.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(kind) && $stable(word_out)
                              && $stable(char_out) && $stable(run_last)))
        else $error("stalled result changed");

endmodule

bind base40_callsign_codec b40cc_checker u_b40cc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (empty),
    .pop       (pop),
    .kind      (kind),
    .word_out  (word_out),
    .char_out  (char_out),
    .run_last  (run_last)
);
